// ----- rtl/ihl_pkg.sv -----
// ihl_pkg: shared constants for the intel hex record loader
// command, result kind and record status codes, buffer sizes, character codes
// no dependencies
package ihl_pkg;

   localparam int MAX_DATA       = 32;
   localparam int BUF_LEN        = MAX_DATA + 5;
   localparam int MIN_LINE_CHARS = 11;
   localparam int MIN_DECODED    = 5;
   localparam int CNT_W          = $clog2(BUF_LEN + 2);
   localparam int MEM_AW         = $clog2(BUF_LEN);

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 24;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 3;
   localparam int BYTES_W  = 24;
   localparam int LINES_W  = 16;
   localparam int SEG_W    = 32;

   localparam logic [CMD_W-1:0] CMD_CHAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DATA_OK  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EOF      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SEG_SET  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd6;
   localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd7;

   localparam logic [7:0] REC_DATA     = 8'h00;
   localparam logic [7:0] REC_EOF      = 8'h01;
   localparam logic [7:0] REC_EXT_SEG  = 8'h02;
   localparam logic [7:0] REC_EXT_LIN  = 8'h04;

   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

   localparam logic [1:0] MODE_BETWEEN = 2'd0;
   localparam logic [1:0] MODE_COLON   = 2'd1;
   localparam logic [1:0] MODE_IGNORE  = 2'd2;
   localparam logic [1:0] MODE_BAD     = 2'd3;

   localparam logic [ADDR_W-1:0] FLASH_END_RESET = 24'd32767;

endpackage

// ----- rtl/ihl_if.sv -----
// ihl channel interfaces: request, response and csr write channels
// valid/ready handshake with source and sink modports
// depends on ihl_pkg
interface ihl_req_if
   import ihl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [CHAR_W-1:0] character;
   modport source (output valid, command, character, input ready);
   modport sink   (input valid, command, character, output ready);
endinterface

interface ihl_rsp_if
   import ihl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   data;
   logic [STATUS_W-1:0] status;
   logic [BYTES_W-1:0]  bytes_loaded;
   logic [LINES_W-1:0]  lines_processed;
   logic                last;
   modport source (output valid, kind, address, data, status, bytes_loaded,
                   lines_processed, last, input ready);
   modport sink   (input valid, kind, address, data, status, bytes_loaded,
                   lines_processed, last, output ready);
endinterface

interface ihl_csr_if
   import ihl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] flash_end;
   modport source (output valid, flash_end, input ready);
   modport sink   (input valid, flash_end, output ready);
endinterface

// ----- rtl/intel_hex_record_loader.sv -----
// intel_hex_record_loader: intel hex text decoder emitting flash byte writes
// depends on ihl_pkg and the channel interfaces in ihl_if.sv
//
// The loader takes one ASCII character (or a begin/finish command) per request
// transfer. While no record is being evaluated, text streams at one character
// per cycle. At a line end the record is evaluated by a sequencer around the
// line buffer memory, which has a single read port: a checksum pass reads the
// decoded bytes, then each flash write is a buffer read followed by a hand-off,
// then one status transfer follows; a finish adds one summary transfer. The
// request side is not ready while a record is being evaluated, and response
// back-pressure stretches each hand-off. The last flag marks the final response
// caused by one request. flash_end is to be written through the csr channel only
// while the loader is idle; the loader does not enforce this. It resets to 32767.
module intel_hex_record_loader
   import ihl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   ihl_req_if.sink   req_chan,
   ihl_rsp_if.source rsp_chan,
   ihl_csr_if.sink   csr_chan
);

   typedef enum logic [2:0] {
      S_IDLE, S_SUM, S_DECIDE, S_DREAD, S_DEMIT, S_STATUS, S_SUMMARY
   } state_type;

   function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   logic [7:0] line_mem [BUF_LEN];
   logic [7:0] rdata_ff;

   state_type           state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [CNT_W-1:0]    dc_ff, dc_in;
   logic [7:0]          cc_ff, cc_in;
   logic [4:0]          half_ff, half_in;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [LINES_W-1:0]  lines_ff, lines_in;
   logic [ADDR_W-1:0]   flash_end_ff, flash_end_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                fin_ff, fin_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic                rdv_ff, rdv_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          rcount_ff, rcount_in;
   logic [7:0]          rahi_ff, rahi_in;
   logic [7:0]          ralo_ff, ralo_in;
   logic [7:0]          rtype_ff, rtype_in;
   logic [7:0]          rd0_ff, rd0_in;
   logic [7:0]          rd1_ff, rd1_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [ADDR_W-1:0]   waddr_ff, waddr_in;

   logic                ov_ff, ov_in;
   logic [KIND_W-1:0]   okind_ff, okind_in;
   logic [ADDR_W-1:0]   oaddr_ff, oaddr_in;
   logic [DATA_W-1:0]   odata_ff, odata_in;
   logic [STATUS_W-1:0] ostatus_ff, ostatus_in;
   logic [BYTES_W-1:0]  obytes_ff, obytes_in;
   logic [LINES_W-1:0]  olines_ff, olines_in;
   logic                olast_ff, olast_in;

   logic                wr_en;
   logic [MEM_AW-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic                rd_en;
   logic [MEM_AW-1:0]   rd_addr;

   logic                take;
   logic                slot;
   logic [4:0]          nib;
   logic                line_ok;
   logic [CNT_W-1:0]    dptr;
   logic [SEG_W-1:0]    rec_addr;
   logic [15:0]         seg_val;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign take = req_chan.valid && (state_ff == S_IDLE);
   assign slot = !ov_ff || rsp_chan.ready;
   assign nib  = hex_nibble(req_chan.character);
   assign line_ok = (mode_ff == MODE_COLON || mode_ff == MODE_BAD)
                    && (cc_ff >= 8'(MIN_LINE_CHARS));
   assign dptr = idx_ff + CNT_W'(4);
   assign rec_addr = seg_ff | {16'd0, rahi_ff, ralo_ff};
   assign seg_val = {rd0_ff, rd1_ff};

   assign rsp_chan.valid           = ov_ff;
   assign rsp_chan.kind            = okind_ff;
   assign rsp_chan.address         = oaddr_ff;
   assign rsp_chan.data            = odata_ff;
   assign rsp_chan.status          = ostatus_ff;
   assign rsp_chan.bytes_loaded    = obytes_ff;
   assign rsp_chan.lines_processed = olines_ff;
   assign rsp_chan.last            = olast_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      dc_in        = dc_ff;
      cc_in        = cc_ff;
      half_in      = half_ff;
      seg_in       = seg_ff;
      bytes_in     = bytes_ff;
      lines_in     = lines_ff;
      flash_end_in = flash_end_ff;
      status_in    = status_ff;
      fin_in       = fin_ff;
      len_in       = len_ff;
      issue_in     = issue_ff;
      pos_in       = pos_ff;
      rdv_in       = 1'b0;
      sum_in       = sum_ff;
      rcount_in    = rcount_ff;
      rahi_in      = rahi_ff;
      ralo_in      = ralo_ff;
      rtype_in     = rtype_ff;
      rd0_in       = rd0_ff;
      rd1_in       = rd1_ff;
      idx_in       = idx_ff;
      waddr_in     = waddr_ff;
      ov_in        = ov_ff && !rsp_chan.ready;
      okind_in     = okind_ff;
      oaddr_in     = oaddr_ff;
      odata_in     = odata_ff;
      ostatus_in   = ostatus_ff;
      obytes_in    = obytes_ff;
      olines_in    = olines_ff;
      olast_in     = olast_ff;
      wr_en        = 1'b0;
      wr_addr      = dc_ff[MEM_AW-1:0];
      wr_data      = {half_ff[3:0], nib[3:0]};
      rd_en        = 1'b0;
      rd_addr      = issue_ff[MEM_AW-1:0];

      if (csr_chan.valid) begin
         flash_end_in = csr_chan.flash_end;
      end

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (req_chan.command == CMD_BEGIN) begin
                  mode_in  = MODE_BETWEEN;
                  dc_in    = '0;
                  cc_in    = '0;
                  half_in  = '0;
                  seg_in   = '0;
                  bytes_in = '0;
                  lines_in = '0;
               end else if (req_chan.command == CMD_FINISH
                            || (req_chan.command == CMD_CHAR
                                && mode_ff != MODE_BETWEEN
                                && (req_chan.character == CH_CR
                                    || req_chan.character == CH_LF))) begin
                  // line end or finish: clear line state, evaluate if it qualifies
                  fin_in   = (req_chan.command == CMD_FINISH);
                  mode_in  = MODE_BETWEEN;
                  dc_in    = '0;
                  cc_in    = '0;
                  half_in  = '0;
                  len_in   = dc_ff;
                  issue_in = '0;
                  sum_in   = '0;
                  if (!line_ok) begin
                     state_in = (req_chan.command == CMD_FINISH) ? S_SUMMARY : S_IDLE;
                  end else if (mode_ff == MODE_BAD || dc_ff < CNT_W'(MIN_DECODED)) begin
                     status_in = ST_SHORT;
                     state_in  = S_STATUS;
                  end else if (dc_ff > CNT_W'(BUF_LEN)) begin
                     status_in = ST_LENGTH;
                     state_in  = S_STATUS;
                  end else begin
                     state_in = S_SUM;
                  end
               end else if (req_chan.command == CMD_CHAR) begin
                  if (mode_ff == MODE_BETWEEN) begin
                     if (req_chan.character != CH_CR && req_chan.character != CH_LF
                         && req_chan.character != CH_SPACE) begin
                        mode_in = (req_chan.character == CH_COLON) ? MODE_COLON
                                                                   : MODE_IGNORE;
                        cc_in   = 8'd1;
                     end
                  end else begin
                     if (cc_ff != 8'hFF) begin
                        cc_in = cc_ff + 8'd1;
                     end
                     if (mode_ff == MODE_COLON) begin
                        if (!nib[4]) begin
                           if (req_chan.character > CH_SPACE) begin
                              mode_in = MODE_BAD;
                           end
                        end else if (half_ff[4]) begin
                           half_in = '0;
                           if (dc_ff < CNT_W'(BUF_LEN)) begin
                              wr_en = 1'b1;
                              dc_in = dc_ff + CNT_W'(1);
                           end else begin
                              dc_in = CNT_W'(BUF_LEN + 1);
                           end
                        end else begin
                           half_in = {1'b1, nib[3:0]};
                        end
                     end
                  end
               end
            end
         end

         S_SUM: begin
            // read pass over the buffer: running sum, header fields captured
            if (issue_ff < len_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
               rdv_in   = 1'b1;
               pos_in   = issue_ff;
            end
            if (rdv_ff) begin
               sum_in = sum_ff + rdata_ff;
               case (pos_ff)
                  CNT_W'(0): rcount_in = rdata_ff;
                  CNT_W'(1): rahi_in   = rdata_ff;
                  CNT_W'(2): ralo_in   = rdata_ff;
                  CNT_W'(3): rtype_in  = rdata_ff;
                  CNT_W'(4): rd0_in    = rdata_ff;
                  CNT_W'(5): rd1_in    = rdata_ff;
                  default: ;
               endcase
               if (pos_ff == len_ff - CNT_W'(1)) begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            idx_in   = '0;
            waddr_in = rec_addr[ADDR_W-1:0];
            state_in = S_STATUS;
            if (sum_ff != 8'd0) begin
               status_in = ST_CHECKSUM;
            end else if ((9'(rcount_ff) + 9'd5) != 9'(len_ff)) begin
               status_in = ST_LENGTH;
            end else begin
               case (rtype_ff)
                  REC_DATA: begin
                     if (rcount_ff == 8'd0 || rec_addr > SEG_W'(flash_end_ff)) begin
                        status_in = ST_REJECTED;
                     end else begin
                        status_in = ST_DATA_OK;
                        state_in  = S_DREAD;
                     end
                  end
                  REC_EOF: begin
                     seg_in    = '0;
                     status_in = ST_EOF;
                  end
                  REC_EXT_SEG, REC_EXT_LIN: begin
                     if (rcount_ff < 8'd2) begin
                        status_in = ST_LENGTH;
                     end else begin
                        seg_in    = (rtype_ff == REC_EXT_SEG) ? {12'd0, seg_val, 4'd0}
                                                              : {seg_val, 16'd0};
                        status_in = ST_SEG_SET;
                     end
                  end
                  default: status_in = ST_IGNORED;
               endcase
            end
         end

         S_DREAD: begin
            rd_en    = 1'b1;
            rd_addr  = dptr[MEM_AW-1:0];
            state_in = S_DEMIT;
         end

         S_DEMIT: begin
            if (slot) begin
               ov_in      = 1'b1;
               okind_in   = KIND_WRITE;
               oaddr_in   = waddr_ff;
               odata_in   = rdata_ff;
               ostatus_in = '0;
               obytes_in  = '0;
               olines_in  = '0;
               olast_in   = 1'b0;
               if (bytes_ff != {BYTES_W{1'b1}}) begin
                  bytes_in = bytes_ff + BYTES_W'(1);
               end
               idx_in   = idx_ff + CNT_W'(1);
               waddr_in = waddr_ff + ADDR_W'(1);
               if ((8'(idx_ff) + 8'd1) == rcount_ff || waddr_ff == flash_end_ff) begin
                  state_in = S_STATUS;
               end else begin
                  state_in = S_DREAD;
               end
            end
         end

         S_STATUS: begin
            if (slot) begin
               ov_in      = 1'b1;
               okind_in   = KIND_STATUS;
               oaddr_in   = '0;
               odata_in   = '0;
               ostatus_in = status_ff;
               obytes_in  = '0;
               olines_in  = '0;
               olast_in   = !fin_ff;
               if (lines_ff != {LINES_W{1'b1}}) begin
                  lines_in = lines_ff + LINES_W'(1);
               end
               state_in = fin_ff ? S_SUMMARY : S_IDLE;
            end
         end

         S_SUMMARY: begin
            if (slot) begin
               ov_in      = 1'b1;
               okind_in   = KIND_SUMMARY;
               oaddr_in   = '0;
               odata_in   = '0;
               ostatus_in = '0;
               obytes_in  = bytes_ff;
               olines_in  = lines_ff;
               olast_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_BETWEEN;
         dc_ff        <= '0;
         cc_ff        <= '0;
         half_ff      <= '0;
         seg_ff       <= '0;
         bytes_ff     <= '0;
         lines_ff     <= '0;
         flash_end_ff <= FLASH_END_RESET;
         fin_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         ov_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         dc_ff        <= dc_in;
         cc_ff        <= cc_in;
         half_ff      <= half_in;
         seg_ff       <= seg_in;
         bytes_ff     <= bytes_in;
         lines_ff     <= lines_in;
         flash_end_ff <= flash_end_in;
         fin_ff       <= fin_in;
         rdv_ff       <= rdv_in;
         ov_ff        <= ov_in;
      end
      status_ff  <= status_in;
      len_ff     <= len_in;
      issue_ff   <= issue_in;
      pos_ff     <= pos_in;
      sum_ff     <= sum_in;
      rcount_ff  <= rcount_in;
      rahi_ff    <= rahi_in;
      ralo_ff    <= ralo_in;
      rtype_ff   <= rtype_in;
      rd0_ff     <= rd0_in;
      rd1_ff     <= rd1_in;
      idx_ff     <= idx_in;
      waddr_ff   <= waddr_in;
      okind_ff   <= okind_in;
      oaddr_ff   <= oaddr_in;
      odata_ff   <= odata_in;
      ostatus_ff <= ostatus_in;
      obytes_ff  <= obytes_in;
      olines_ff  <= olines_in;
      olast_ff   <= olast_in;
   end

endmodule

// ----- dv/intel_hex_record_loader_tb.sv -----
// testbench for intel_hex_record_loader: hex text in, flash writes and record status out
// keeps a cycle-free model of the loader and checks every result transfer in order
// depends on ihl_pkg, the channel interfaces in ihl_if.sv and the loader rtl
module intel_hex_record_loader_tb;
   import ihl_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam int EOL_CR = 0;
   localparam int EOL_LF = 1;
   localparam int EOL_CRLF = 2;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS = 370;
   localparam int MAX_REPORTS = 100;

   typedef logic [7:0] byte_q_t[$];

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [BYTES_W-1:0]  bytes_loaded;
      logic [LINES_W-1:0]  lines_processed;
      logic                last;
   } loader_rsp_t;

   logic clock;
   logic reset;
   bit   calm;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned mismatches;

   ihl_req_if req_chan();
   ihl_rsp_if rsp_chan();
   ihl_csr_if csr_chan();

   intel_hex_record_loader DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // loader state as seen from outside
   logic [7:0]          line_bytes [BUF_LEN];
   int unsigned         decoded_len;
   int unsigned         line_chars;
   bit                  nibble_held;
   logic [3:0]          held_nibble;
   logic [1:0]          text_mode;
   logic [SEG_W-1:0]    seg_base;
   logic [BYTES_W-1:0]  loaded_bytes;
   logic [LINES_W-1:0]  processed_lines;
   logic [ADDR_W-1:0]   flash_limit;

   loader_rsp_t due_results[$];
   loader_rsp_t step_results[$];

   function automatic void push_result(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                       logic [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                                       logic [BYTES_W-1:0] bytes, logic [LINES_W-1:0] lines);
      loader_rsp_t r;
      r.kind = kind;
      r.address = addr;
      r.data = data;
      r.status = status;
      r.bytes_loaded = bytes;
      r.lines_processed = lines;
      r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void clear_line();
      decoded_len = 0;
      line_chars = 0;
      nibble_held = 1'b0;
      held_nibble = '0;
      text_mode = MODE_BETWEEN;
   endfunction

   function automatic void reset_model();
      foreach (line_bytes[k]) line_bytes[k] = '0;
      clear_line();
      seg_base = '0;
      loaded_bytes = '0;
      processed_lines = '0;
      flash_limit = FLASH_END_RESET;
   endfunction

   function automatic logic [STATUS_W-1:0] record_status();
      logic [7:0]       sum;
      logic [7:0]       neg_sum;
      int unsigned      count;
      int unsigned      i;
      logic [SEG_W-1:0] addr;
      logic [15:0]      base;
      sum = '0;
      if (text_mode == MODE_BAD || decoded_len < MIN_DECODED) return ST_SHORT;
      if (decoded_len > BUF_LEN) return ST_LENGTH;
      for (i = 0; i + 1 < decoded_len; i++) sum = sum + line_bytes[i];
      neg_sum = 8'd0 - sum;
      if (neg_sum != line_bytes[decoded_len - 1]) return ST_CHECKSUM;
      count = line_bytes[0];
      if (count + 5 != decoded_len) return ST_LENGTH;
      case (line_bytes[3])
         REC_DATA: begin
            addr = seg_base | {16'd0, line_bytes[1], line_bytes[2]};
            if (count == 0 || addr > {8'd0, flash_limit}) return ST_REJECTED;
            for (i = 0; i < count; i++) begin
               if (addr + i <= {8'd0, flash_limit}) begin
                  push_result(KIND_WRITE, ADDR_W'(addr + i), line_bytes[4 + i], '0, '0, '0);
                  if (loaded_bytes != '1) loaded_bytes++;
               end
            end
            return ST_DATA_OK;
         end
         REC_EOF: begin
            seg_base = '0;
            return ST_EOF;
         end
         REC_EXT_SEG, REC_EXT_LIN: begin
            if (count < 2) return ST_LENGTH;
            base = {line_bytes[4], line_bytes[5]};
            if (line_bytes[3] == REC_EXT_SEG) seg_base = {12'd0, base, 4'd0};
            else seg_base = {base, 16'd0};
            return ST_SEG_SET;
         end
         default: return ST_IGNORED;
      endcase
   endfunction

   function automatic void close_line();
      logic [STATUS_W-1:0] st;
      if ((text_mode == MODE_COLON || text_mode == MODE_BAD) &&
          line_chars >= MIN_LINE_CHARS) begin
         st = record_status();
         push_result(KIND_STATUS, '0, '0, st, '0, '0);
         if (processed_lines != '1) processed_lines++;
      end
      clear_line();
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic void take_char(logic [CHAR_W-1:0] c);
      int v;
      if (text_mode == MODE_BETWEEN) begin
         if (c == CH_CR || c == CH_LF || c == CH_SPACE) return;
         text_mode = (c == CH_COLON) ? MODE_COLON : MODE_IGNORE;
         line_chars = 1;
         return;
      end
      if (c == CH_CR || c == CH_LF) begin
         close_line();
         return;
      end
      if (line_chars < 255) line_chars++;
      if (text_mode != MODE_COLON) return;
      v = hex_digit(c);
      if (v < 0) begin
         if (c > CH_SPACE) text_mode = MODE_BAD;
         return;
      end
      if (nibble_held) begin
         if (decoded_len < BUF_LEN) begin
            line_bytes[decoded_len] = {held_nibble, 4'(v)};
            decoded_len++;
         end else begin
            decoded_len = BUF_LEN + 1;
         end
         nibble_held = 1'b0;
      end else begin
         nibble_held = 1'b1;
         held_nibble = 4'(v);
      end
   endfunction

   function automatic void loader_step(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
      step_results.delete();
      case (cmd)
         CMD_CHAR: take_char(ch);
         CMD_BEGIN: begin
            clear_line();
            seg_base = '0;
            loaded_bytes = '0;
            processed_lines = '0;
         end
         CMD_FINISH: begin
            close_line();
            push_result(KIND_SUMMARY, '0, '0, '0, loaded_bytes, processed_lines);
         end
         default: ;
      endcase
      if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[k]) due_results.push_back(step_results[k]);
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_seen, name, got, want));
   endtask

   task automatic check_result();
      loader_rsp_t want;
      results_seen++;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result %0d of kind %0d with nothing expected",
                                   results_seen, rsp_chan.kind));
         return;
      end
      want = due_results.pop_front();
      check_field("kind", rsp_chan.kind, want.kind);
      check_field("address", rsp_chan.address, want.address);
      check_field("data", rsp_chan.data, want.data);
      check_field("status", rsp_chan.status, want.status);
      check_field("bytes_loaded", rsp_chan.bytes_loaded, want.bytes_loaded);
      check_field("lines_processed", rsp_chan.lines_processed, want.lines_processed);
      check_field("last", rsp_chan.last, want.last);
   endtask

   // model and checker both act on the transfers of one edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) flash_limit = csr_chan.flash_end;
         if (req_chan.valid && req_chan.ready) loader_step(req_chan.command, req_chan.character);
         if (rsp_chan.valid && rsp_chan.ready) check_result();
      end
   end

   always @(negedge clock) rsp_chan.ready <= calm || ($urandom_range(99) >= 22);

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
      if (!calm && $urandom_range(99) < 22)
         repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 2)) @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.command = cmd;
      req_chan.character = ch;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      req_chan.valid = 1'b0;
      if (cmd != CMD_RESERVED) items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(CMD_CHAR, s[i]);
   endtask

   task automatic send_chars(byte_q_t txt);
      foreach (txt[k]) send_item(CMD_CHAR, txt[k]);
   endtask

   task automatic send_eol(int style);
      if (style != EOL_LF) send_item(CMD_CHAR, CH_CR);
      if (style != EOL_CR) send_item(CMD_CHAR, CH_LF);
   endtask

   task automatic wait_drain();
      while (due_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_flash_end(logic [ADDR_W-1:0] value);
      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.flash_end = value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   function automatic byte_q_t random_bytes(int unsigned n);
      byte_q_t q;
      repeat (n) q.push_back(8'($urandom));
      return q;
   endfunction

   // count, offset, type, payload, then the two's complement checksum
   function automatic byte_q_t build_record(logic [7:0] count, logic [15:0] offset,
                                            logic [7:0] rtype, byte_q_t payload);
      byte_q_t    rec;
      logic [7:0] sum;
      rec.push_back(count);
      rec.push_back(offset[15:8]);
      rec.push_back(offset[7:0]);
      rec.push_back(rtype);
      foreach (payload[k]) rec.push_back(payload[k]);
      sum = '0;
      foreach (rec[k]) sum = sum + rec[k];
      rec.push_back(8'd0 - sum);
      return rec;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 10) return 8'h30 + {4'h0, n};
      return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
   endfunction

   function automatic byte_q_t record_chars(byte_q_t rec, bit lower);
      byte_q_t txt;
      txt.push_back(CH_COLON);
      foreach (rec[k]) begin
         txt.push_back(hex_char(rec[k][7:4], lower));
         txt.push_back(hex_char(rec[k][3:0], lower));
      end
      return txt;
   endfunction

   task automatic send_rec(logic [7:0] count, logic [15:0] offset, logic [7:0] rtype,
                           byte_q_t payload, bit lower, int eol);
      send_chars(record_chars(build_record(count, offset, rtype, payload), lower));
      send_eol(eol);
   endtask

   task automatic test_data_records();
      byte_q_t bytes;
      send_item(CMD_BEGIN, 8'h00);
      send_item(CMD_CHAR, CH_CR);
      send_item(CMD_CHAR, CH_LF);
      send_item(CMD_CHAR, CH_SPACE);
      bytes = {8'h00, 8'hFF};
      send_rec(8'd2, 16'h0000, REC_DATA, bytes, 1'b0, EOL_CRLF);
      // crosses flash_end, only the first two bytes land
      send_rec(8'd4, 16'h7FFE, REC_DATA, random_bytes(4), 1'b1, EOL_LF);
      send_rec(8'd1, 16'h8000, REC_DATA, random_bytes(1), 1'b0, EOL_CR);
      send_rec(8'd0, 16'h0010, REC_DATA, random_bytes(0), 1'b0, EOL_LF);
      send_rec(8'(MAX_DATA), 16'h0100, REC_DATA, random_bytes(MAX_DATA), 1'b1, EOL_CRLF);
      send_item(CMD_FINISH, 8'h00);
   endtask

   task automatic test_record_types();
      byte_q_t bytes;
      bytes = {8'h00, 8'h08};
      send_rec(8'd2, 16'h0000, REC_EXT_SEG, bytes, 1'b0, EOL_CRLF);
      send_rec(8'd3, 16'h0010, REC_DATA, random_bytes(3), 1'b0, EOL_CRLF);
      send_rec(8'd0, 16'h0000, REC_EOF, random_bytes(0), 1'b1, EOL_LF);
      bytes = {8'h00, 8'h00, 8'hAB, 8'hCD};
      send_rec(8'd4, 16'h0000, REC_EXT_LIN, bytes, 1'b0, EOL_CR);
      send_rec(8'd1, 16'h0000, REC_EXT_SEG, random_bytes(1), 1'b0, EOL_LF);
      send_rec(8'd0, 16'h0000, REC_EXT_LIN, random_bytes(0), 1'b1, EOL_LF);
      send_rec(8'd4, 16'h1234, 8'h03, random_bytes(4), 1'b0, EOL_CRLF);
      send_rec(8'd2, 16'h0000, 8'h05, random_bytes(2), 1'b1, EOL_LF);
      send_rec(8'd1, 16'hFFFF, 8'hFF, random_bytes(1), 1'b0, EOL_LF);
      bytes = {8'h00, 8'h01};
      send_rec(8'd2, 16'h0000, REC_EXT_LIN, bytes, 1'b0, EOL_LF);
      send_rec(8'd1, 16'h0000, REC_DATA, random_bytes(1), 1'b0, EOL_LF);
      send_rec(8'd0, 16'h0000, REC_EOF, random_bytes(0), 1'b0, EOL_LF);
      send_item(CMD_FINISH, 8'hFF);
   endtask

   task automatic test_malformed_lines();
      byte_q_t rec;
      byte_q_t txt;
      rec = build_record(8'd2, 16'h1234, REC_DATA, random_bytes(2));
      rec[rec.size() - 1] = rec[rec.size() - 1] ^ 8'h5A;
      send_chars(record_chars(rec, 1'b0));
      send_eol(EOL_LF);
      // count field says three, two bytes follow
      send_rec(8'd3, 16'h0020, REC_DATA, random_bytes(2), 1'b0, EOL_LF);
      txt = record_chars(build_record(8'd1, 16'h0030, REC_DATA, random_bytes(1)), 1'b0);
      txt.insert(5, "G");
      send_chars(txt);
      send_eol(EOL_CRLF);
      txt = record_chars(build_record(8'd1, 16'h0030, REC_DATA, random_bytes(1)), 1'b1);
      txt.insert(3, 8'h80);
      send_chars(txt);
      send_eol(EOL_LF);
      txt = record_chars(build_record(8'd1, 16'h0030, REC_DATA, random_bytes(1)), 1'b0);
      txt.insert(7, CH_COLON);
      send_chars(txt);
      send_eol(EOL_LF);
      // four bytes padded with blanks past the minimum length
      send_text(":00000000");
      send_item(CMD_CHAR, CH_SPACE);
      send_item(CMD_CHAR, CH_TAB);
      send_item(CMD_CHAR, CH_SPACE);
      send_eol(EOL_LF);
      send_text(":00000001F");
      send_eol(EOL_LF);
      send_text(":00000001FF");
      send_eol(EOL_CR);
      send_text("hello world, 1234");
      send_eol(EOL_LF);
      send_item(CMD_CHAR, 8'h00);
      send_text(":00000001FF");
      send_eol(EOL_LF);
      send_rec(8'(MAX_DATA + 1), 16'h0000, REC_DATA, random_bytes(MAX_DATA + 1), 1'b0,
               EOL_LF);
      txt = record_chars(build_record(8'd1, 16'h0040, REC_DATA, random_bytes(1)), 1'b1);
      txt.push_back("7");
      send_chars(txt);
      send_eol(EOL_CRLF);
      wait_drain();
      send_chars(record_chars(build_record(8'd2, 16'h0050, REC_DATA, random_bytes(2)), 1'b0));
      send_item(CMD_FINISH, 8'hA5);
      send_text(":0200");
      send_item(CMD_BEGIN, 8'h5A);
      send_item(CMD_RESERVED, 8'hFF);
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_FINISH, 8'hFF);
   endtask

   task automatic test_flash_end();
      byte_q_t bytes;
      write_flash_end(24'd0);
      send_item(CMD_BEGIN, 8'h00);
      send_rec(8'd3, 16'h0000, REC_DATA, random_bytes(3), 1'b0, EOL_LF);
      send_rec(8'd1, 16'h0001, REC_DATA, random_bytes(1), 1'b0, EOL_LF);
      send_item(CMD_FINISH, 8'h00);
      write_flash_end(24'hFFFFFF);
      bytes = {8'h00, 8'hFF};
      send_rec(8'd2, 16'h0000, REC_EXT_LIN, bytes, 1'b0, EOL_LF);
      send_rec(8'd4, 16'hFFFE, REC_DATA, random_bytes(4), 1'b1, EOL_LF);
      bytes = {8'h01, 8'h00};
      send_rec(8'd2, 16'h0000, REC_EXT_LIN, bytes, 1'b0, EOL_LF);
      send_rec(8'd1, 16'h0000, REC_DATA, random_bytes(1), 1'b0, EOL_LF);
      bytes = {8'hFF, 8'hFF};
      send_rec(8'd2, 16'h0000, REC_EXT_SEG, bytes, 1'b0, EOL_LF);
      send_rec(8'd2, 16'hFFFF, REC_DATA, random_bytes(2), 1'b0, EOL_CRLF);
      send_item(CMD_FINISH, 8'h00);
      write_flash_end(24'($urandom));
      send_rec(8'd5, 16'($urandom), REC_DATA, random_bytes(5), 1'b0, EOL_LF);
      send_item(CMD_FINISH, 8'h00);
   endtask

   task automatic send_random_line();
      byte_q_t     payload;
      byte_q_t     rec;
      byte_q_t     txt;
      logic [7:0]  rtype;
      logic [7:0]  count_field;
      logic [7:0]  bad;
      int unsigned count;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 3) begin
         send_item(CMD_BEGIN, 8'($urandom));
         return;
      end
      if (pick < 6) begin
         send_item(CMD_RESERVED, 8'($urandom));
         return;
      end
      if (pick < 10) begin
         repeat ($urandom_range(1, 14)) send_item(CMD_CHAR, 8'($urandom));
         send_eol($urandom_range(2));
         return;
      end
      pick = $urandom_range(99);
      if (pick < 60) rtype = REC_DATA;
      else if (pick < 70) rtype = REC_EOF;
      else if (pick < 78) rtype = REC_EXT_SEG;
      else if (pick < 86) rtype = REC_EXT_LIN;
      else rtype = 8'($urandom);
      if (rtype == REC_DATA)
         count = ($urandom_range(9) != 0) ? $urandom_range(1, 8) : $urandom_range(0, MAX_DATA + 1);
      else if (rtype == REC_EOF)
         count = ($urandom_range(3) != 0) ? 0 : $urandom_range(0, 3);
      else
         count = $urandom_range(0, 4);
      payload = random_bytes(count);
      // keep most segment bases inside the 24-bit flash range
      if ((rtype == REC_EXT_SEG || rtype == REC_EXT_LIN) && count >= 2 && $urandom_range(1))
         payload[0] = 8'h00;
      count_field = 8'(count);
      if ($urandom_range(99) < 5) count_field = 8'($urandom);
      rec = build_record(count_field, 16'($urandom), rtype, payload);
      if ($urandom_range(99) < 8)
         rec[rec.size() - 1] = rec[rec.size() - 1] ^ 8'($urandom_range(1, 255));
      txt = record_chars(rec, $urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 5) begin
         case ($urandom_range(3))
            0: bad = "G";
            1: bad = CH_COLON;
            2: bad = "~";
            default: bad = 8'($urandom_range(128, 255));
         endcase
         txt.insert($urandom_range(1, txt.size() - 1), bad);
      end else if (pick < 9) begin
         repeat ($urandom_range(1, txt.size() - 1)) void'(txt.pop_back());
      end else if (pick < 15) begin
         txt.insert($urandom_range(1, txt.size() - 1), $urandom_range(1) ? CH_SPACE : CH_TAB);
      end
      if ($urandom_range(3) == 0) send_item(CMD_CHAR, $urandom_range(1) ? CH_SPACE : CH_LF);
      send_chars(txt);
      if ($urandom_range(99) < 5) send_item(CMD_FINISH, 8'($urandom));
      else send_eol($urandom_range(2));
   endtask

   task automatic test_random_stream();
      int unsigned goal;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: write_flash_end(24'($urandom_range(0, 24'h00FFFF)));
            1: write_flash_end(24'hFFFFFF);
            default: write_flash_end(24'($urandom));
         endcase
         calm = (phase == 1);
         send_item(CMD_BEGIN, 8'($urandom));
         goal = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < goal) send_random_line();
         send_item(CMD_FINISH, 8'($urandom));
      end
      calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      items_sent = 0;
      results_seen = 0;
      mismatches = 0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_CHAR;
      req_chan.character = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.flash_end = FLASH_END_RESET;
      reset_model();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_data_records();
      test_record_types();
      test_malformed_lines();
      test_flash_end();
      test_random_stream();
      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("intel_hex_record_loader_tb passed");
      end else begin
         $display("intel_hex_record_loader_tb failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("intel_hex_record_loader_tb failed");
      $finish;
   end

endmodule
